// ===== hw/rtl/linked_message_queue_pool_macros.svh =====
// Assertion macros shared by the checker.
`ifndef LINKED_MESSAGE_QUEUE_POOL_MACROS_SVH
`define LINKED_MESSAGE_QUEUE_POOL_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LMQP_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LMQP_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/lmqp_pkg.sv =====
`default_nettype none
package lmqp_pkg;
    localparam int HANDLE_MAX = 8192;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_COUNT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_POOL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DISPATCH,
        S_ENQ_RD,
        S_ENQ_WAIT,
        S_ENQ_WR,
        S_READ_WAIT,
        S_READ_DONE,
        S_WALK_RD,
        S_WALK_WAIT,
        S_WALK_CHK,
        S_UNLINK,
        S_FREE,
        S_OUT
    } fsm_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lmqp_slot_mem.sv =====
`default_nettype none
// Slot memory with one write port, one read port and registered read data.
module lmqp_slot_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/linked_message_queue_pool.sv =====
`default_nettype none
// Channel   Dir  Fields (tdata/tuser)
// s_axis    in   cmd, chat_state, msg_type, msg_time, payload, remove_handle
// m_axis    out  status, out_handle, head_time, head_type, head_payload, msg_count
// cfg       in   active_mask
// After reset a clearing pass builds the free chain and empties the client table, one
// entry a cycle (the larger of MESSAGE_SLOTS and the client table depth); no item is taken.
// From acceptance to the result: count, bad client, empty queue and full pool go straight
// to the result; a read waits on the head slot's data; an enqueue reads the free link, then
// writes; a remove checks each queue entry in turn, then unlinks and frees the match.
// s_tready is low while an item is worked on or its result waits on m_axis.
module linked_message_queue_pool #(
    parameter int MESSAGE_SLOTS = 1024,
    parameter int CLIENT_SLOTS  = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd[1:0], chat_state[8:2], msg_type[16:9], msg_time[48:17],
    // payload[112:49], remove_handle[126:113], zero pad [127]
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], out_handle[15:2], head_time[47:16], head_type[55:48],
    // head_payload[119:56], msg_count[130:120], zero pad [135:131]
    output logic      [135:0] m_tdata
);
    localparam int AW = $clog2(MESSAGE_SLOTS) + 1;
    localparam int IW = $clog2(MESSAGE_SLOTS);
    localparam int CW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam logic [AW-1:0] NIL = AW'(MESSAGE_SLOTS);
    localparam int DW = 8 + 32 + 64 + 14;
    localparam int INIT_N = (MESSAGE_SLOTS > (1 << CW)) ? MESSAGE_SLOTS : (1 << CW);
    localparam int NW = $clog2(INIT_N) + 1;
    // Client entry: head, tail, length, last handle, from the lowest bit up.
    localparam int CLW = 2 * AW + 11 + 14;

    lmqp_pkg::fsm_t state_reg, state_next;

    logic [63:0]  mask_reg;
    logic [127:0] in_reg;
    logic [AW-1:0] free_head_reg, free_head_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] nx_reg, nx_next, pv_reg, pv_next;
    logic [NW-1:0] init_reg;
    logic [1:0]    step_reg, step_next;
    logic [IW:0]   walk_reg, walk_next;
    logic [135:0]  out_reg;
    logic          out_vld_reg;
    logic [CLW-1:0] cl_reg;

    // Field views of the held item.
    logic [1:0]  f_cmd;
    logic [6:0]  f_cs;
    logic [13:0] f_rh;
    logic [CW-1:0] ci;
    assign f_cmd = in_reg[1:0];
    assign f_cs  = in_reg[8:2];
    assign f_rh  = in_reg[126:113];
    assign ci    = CW'(f_cs - 7'd1);

    logic bad;
    assign bad = (f_cs == 7'd0) || (32'(f_cs) > CLIENT_SLOTS) ||
                 !mask_reg[6'(f_cs - 7'd1)];

    // Link and data memories: one write and one read port each; data uses one address for both.
    logic          nxt_we, prv_we, dat_we;
    logic [IW-1:0] nxt_wa, prv_wa, nxt_ra, prv_ra, dat_a;
    logic [AW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;
    logic [DW-1:0] dat_wd, dat_rd;

    lmqp_slot_mem #(.DEPTH(MESSAGE_SLOTS), .WIDTH(AW)) u_next (
        .aclk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra),
        .rdata(nxt_rd));
    lmqp_slot_mem #(.DEPTH(MESSAGE_SLOTS), .WIDTH(AW)) u_prev (
        .aclk, .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(prv_ra),
        .rdata(prv_rd));
    lmqp_slot_mem #(.DEPTH(MESSAGE_SLOTS), .WIDTH(DW)) u_data (
        .aclk, .we(dat_we), .waddr(dat_a), .wdata(dat_wd), .raddr(dat_a),
        .rdata(dat_rd));

    // Client table. While idle it is read at the index of the offered item, so
    // the entry of an accepted item is ready in the dispatch cycle.
    logic           cl_we;
    logic [CW-1:0]  cl_wa, cl_ra;
    logic [CLW-1:0] cl_wd, cl_rd;
    assign cl_ra = (state_reg == lmqp_pkg::S_IDLE) ? CW'(s_tdata[8:2] - 7'd1) : ci;

    lmqp_slot_mem #(.DEPTH(1 << CW), .WIDTH(CLW)) u_client (
        .aclk, .we(cl_we), .waddr(cl_wa), .wdata(cl_wd), .raddr(cl_ra),
        .rdata(cl_rd));

    logic [AW-1:0] rd_head;
    logic [10:0]   rd_len;
    logic [AW-1:0] c_head, c_tail;
    logic [10:0]   c_len;
    logic [13:0]   c_lasth;
    assign rd_head = cl_rd[AW-1:0];
    assign rd_len  = cl_rd[2*AW+10:2*AW];
    assign c_head  = cl_reg[AW-1:0];
    assign c_tail  = cl_reg[2*AW-1:AW];
    assign c_len   = cl_reg[2*AW+10:2*AW];
    assign c_lasth = cl_reg[CLW-1:2*AW+11];

    logic [13:0] new_h;
    assign new_h = (c_lasth >= 14'(lmqp_pkg::HANDLE_MAX)) ? 14'd1 : c_lasth + 14'd1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lmqp_pkg::S_INIT:
                if (init_reg == NW'(INIT_N - 1)) state_next = lmqp_pkg::S_IDLE;
            lmqp_pkg::S_IDLE:
                if (s_tvalid && s_tready) state_next = lmqp_pkg::S_DISPATCH;
            lmqp_pkg::S_DISPATCH:
                if (bad) state_next = lmqp_pkg::S_OUT;
                else begin
                    unique case (lmqp_pkg::cmd_t'(f_cmd))
                        lmqp_pkg::CMD_ENQ:
                            state_next = (free_head_reg == NIL) ? lmqp_pkg::S_OUT
                                                                : lmqp_pkg::S_ENQ_RD;
                        lmqp_pkg::CMD_REMOVE:
                            state_next = (rd_head == NIL) ? lmqp_pkg::S_OUT
                                                          : lmqp_pkg::S_WALK_RD;
                        lmqp_pkg::CMD_READ:
                            state_next = (rd_head == NIL) ? lmqp_pkg::S_OUT
                                                          : lmqp_pkg::S_READ_WAIT;
                        default: state_next = lmqp_pkg::S_OUT;
                    endcase
                end
            lmqp_pkg::S_ENQ_RD:    state_next = lmqp_pkg::S_ENQ_WAIT;
            lmqp_pkg::S_ENQ_WAIT:  state_next = lmqp_pkg::S_ENQ_WR;
            lmqp_pkg::S_ENQ_WR:
                if (step_reg == 2'd2) state_next = lmqp_pkg::S_OUT;
            lmqp_pkg::S_READ_WAIT: state_next = lmqp_pkg::S_READ_DONE;
            lmqp_pkg::S_READ_DONE: state_next = lmqp_pkg::S_OUT;
            lmqp_pkg::S_WALK_RD:   state_next = lmqp_pkg::S_WALK_WAIT;
            lmqp_pkg::S_WALK_WAIT: state_next = lmqp_pkg::S_WALK_CHK;
            lmqp_pkg::S_WALK_CHK:
                if (dat_rd[13:0] == f_rh) state_next = lmqp_pkg::S_UNLINK;
                else if (nxt_rd == NIL || walk_reg == (IW+1)'(MESSAGE_SLOTS - 1))
                    state_next = lmqp_pkg::S_OUT;
                else state_next = lmqp_pkg::S_WALK_RD;
            lmqp_pkg::S_UNLINK:    state_next = lmqp_pkg::S_FREE;
            lmqp_pkg::S_FREE:
                if (step_reg == 2'd1) state_next = lmqp_pkg::S_OUT;
            lmqp_pkg::S_OUT:
                if (!out_vld_reg) state_next = lmqp_pkg::S_IDLE;
            default: state_next = lmqp_pkg::S_IDLE;
        endcase
    end

    // Memory controls and datapath next values.
    always_comb begin
        nxt_we = 1'b0; prv_we = 1'b0; dat_we = 1'b0; cl_we = 1'b0;
        nxt_wa = cur_reg[IW-1:0]; prv_wa = cur_reg[IW-1:0];
        nxt_wd = NIL; prv_wd = NIL;
        nxt_ra = cur_reg[IW-1:0]; prv_ra = cur_reg[IW-1:0];
        dat_a  = cur_reg[IW-1:0];
        dat_wd = {in_reg[112:49], in_reg[48:17], in_reg[16:9], new_h};
        cl_wa  = ci;
        cl_wd  = cl_reg;
        free_head_next = free_head_reg;
        cur_next = cur_reg; nx_next = nx_reg; pv_next = pv_reg;
        step_next = 2'd0; walk_next = walk_reg;
        unique case (state_reg)
            lmqp_pkg::S_INIT: begin
                nxt_we = (init_reg < NW'(MESSAGE_SLOTS));
                prv_we = (init_reg < NW'(MESSAGE_SLOTS));
                nxt_wa = init_reg[IW-1:0]; prv_wa = init_reg[IW-1:0];
                nxt_wd = AW'(init_reg + NW'(1));
                prv_wd = (init_reg == '0) ? NIL : AW'(init_reg - NW'(1));
                cl_we  = 1'b1;
                cl_wa  = init_reg[CW-1:0];
                cl_wd  = {14'd0, 11'd0, NIL, NIL};
            end
            lmqp_pkg::S_DISPATCH: begin
                cur_next  = (f_cmd == lmqp_pkg::CMD_ENQ) ? free_head_reg : rd_head;
                walk_next = '0;
            end
            lmqp_pkg::S_ENQ_RD, lmqp_pkg::S_ENQ_WAIT: ;
            lmqp_pkg::S_ENQ_WR: begin
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0: begin
                        // Take the slot, store it and link it behind the old tail.
                        free_head_next = nxt_rd;
                        dat_we = 1'b1;
                        prv_we = 1'b1; prv_wd = c_tail;
                        if (c_tail != NIL) begin
                            nxt_we = 1'b1; nxt_wa = c_tail[IW-1:0];
                            nxt_wd = cur_reg;
                        end
                        cl_we = 1'b1;
                        cl_wd = {new_h, c_len + 11'd1, cur_reg,
                                 (c_tail == NIL) ? cur_reg : c_head};
                    end
                    2'd1: begin
                        if (free_head_reg != NIL) begin
                            prv_we = 1'b1; prv_wa = free_head_reg[IW-1:0];
                            prv_wd = NIL;
                        end
                    end
                    default: begin
                        // The new slot ends the queue.
                        nxt_we = 1'b1; nxt_wd = NIL;
                    end
                endcase
            end
            lmqp_pkg::S_WALK_CHK: begin
                nx_next = nxt_rd; pv_next = prv_rd;
                if (dat_rd[13:0] != f_rh) begin
                    cur_next  = nxt_rd;
                    walk_next = walk_reg + 1'b1;
                end
            end
            lmqp_pkg::S_UNLINK: begin
                if (nx_reg != NIL) begin
                    prv_we = 1'b1; prv_wa = nx_reg[IW-1:0]; prv_wd = pv_reg;
                end
                if (pv_reg != NIL) begin
                    nxt_we = 1'b1; nxt_wa = pv_reg[IW-1:0]; nxt_wd = nx_reg;
                end
                cl_we = 1'b1;
                cl_wd = {c_lasth, (c_len != 11'd0) ? c_len - 11'd1 : 11'd0,
                         (nx_reg == NIL) ? pv_reg : c_tail,
                         (pv_reg == NIL) ? nx_reg : c_head};
            end
            lmqp_pkg::S_FREE: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd0) begin
                    if (free_head_reg != NIL) begin
                        prv_we = 1'b1; prv_wa = free_head_reg[IW-1:0]; prv_wd = cur_reg;
                    end
                end else begin
                    prv_we = 1'b1; prv_wd = NIL;
                    nxt_we = 1'b1; nxt_wd = free_head_reg;
                    free_head_next = cur_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == lmqp_pkg::S_IDLE) && !out_vld_reg;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lmqp_pkg::S_INIT;
            init_reg      <= '0;
            mask_reg      <= '0;
            free_head_reg <= '0;
            out_vld_reg   <= 1'b0;
            step_reg      <= 2'd0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            free_head_reg <= free_head_next;
            if (state_reg == lmqp_pkg::S_INIT) init_reg <= init_reg + NW'(1);
            if (cfg_we) mask_reg <= cfg_wdata;
            if (m_tvalid && m_tready) out_vld_reg <= 1'b0;
            if (state_reg == lmqp_pkg::S_OUT && !out_vld_reg) out_vld_reg <= 1'b1;
        end
    end

    // Payload registers and result assembly.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_reg <= s_tdata;
        cur_reg  <= cur_next;
        nx_reg   <= nx_next;
        pv_reg   <= pv_next;
        walk_reg <= walk_next;
        if (state_reg == lmqp_pkg::S_DISPATCH) begin
            cl_reg  <= cl_rd;
            out_reg <= '0;
            if (bad) out_reg[1:0] <= lmqp_pkg::ST_BAD;
            else begin
                out_reg[130:120] <= rd_len;
                if (f_cmd == lmqp_pkg::CMD_ENQ && free_head_reg == NIL)
                    out_reg[1:0] <= lmqp_pkg::ST_POOL;
                if (f_cmd != lmqp_pkg::CMD_ENQ && f_cmd != lmqp_pkg::CMD_COUNT)
                    out_reg[1:0] <= lmqp_pkg::ST_NOTFOUND;
            end
        end
        if (state_reg == lmqp_pkg::S_ENQ_WR && step_reg == 2'd0) begin
            out_reg[15:2]    <= new_h;
            out_reg[130:120] <= c_len + 11'd1;
        end
        if (state_reg == lmqp_pkg::S_READ_DONE) begin
            out_reg[1:0]    <= lmqp_pkg::ST_OK;
            out_reg[15:2]   <= dat_rd[13:0];
            out_reg[55:48]  <= dat_rd[21:14];
            out_reg[47:16]  <= dat_rd[53:22];
            out_reg[119:56] <= dat_rd[117:54];
        end
        if (state_reg == lmqp_pkg::S_UNLINK) begin
            out_reg[1:0] <= lmqp_pkg::ST_OK;
            out_reg[130:120] <= (c_len != 11'd0) ? c_len - 11'd1 : 11'd0;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lmqp_checker.sv =====
`default_nettype none
`include "linked_message_queue_pool_macros.svh"
// Port-level checks on the pool.
module lmqp_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata
);
    // One item in flight: no new item while a result waits.
    `LMQP_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    // An accepted item produces no result in the very next cycle.
    `LMQP_ASSERT_NEXT(a_latency, aclk, aresetn, s_tvalid && s_tready, !m_tvalid)
    // A bad client result carries only its status.
    `LMQP_ASSERT_IMP(a_bad_zero, aclk, aresetn,
        m_tvalid && m_tdata[1:0] == 2'd1, m_tdata[135:2] == '0)
    // A held result keeps its data.
    `LMQP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
endmodule

bind linked_message_queue_pool lmqp_checker u_lmqp_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata);
`default_nettype wire

// ===== test/lmqp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lmqp_scoreboard (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [135:0] m_tdata,
    output int                errors,
    output int                pending
);
    localparam int SLOTS   = 1024;
    localparam int CLIENTS = 64;
    localparam logic [10:0] NULL_SLOT = 11'd1024;

    typedef struct packed {
        lmqp_pkg::status_t status;
        logic [13:0] handle;
        logic [31:0] htime;
        logic [7:0]  htype;
        logic [63:0] hpay;
        logic [10:0] count;
    } reply_t;

    // Mirror of the pool: link memories, slot contents and per-client queues.
    logic [63:0] client_mask;
    logic [10:0] link_next [SLOTS];
    logic [10:0] link_prev [SLOTS];
    logic [13:0] slot_hnd  [SLOTS];
    logic [31:0] slot_tm   [SLOTS];
    logic [7:0]  slot_ty   [SLOTS];
    logic [63:0] slot_pay  [SLOTS];
    logic [10:0] free_top;
    logic [10:0] q_first [CLIENTS];
    logic [10:0] q_last  [CLIENTS];
    logic [10:0] q_len   [CLIENTS];
    logic [13:0] q_hnd   [CLIENTS];
    reply_t      replies_due [$];

    function automatic bit valid_slot(logic [10:0] s);
        return s < NULL_SLOT;
    endfunction

    function automatic void clear_pool();
        for (int i = 0; i < SLOTS; i++) begin
            link_next[i] = (i + 1 < SLOTS) ? 11'(i + 1) : NULL_SLOT;
            link_prev[i] = (i == 0) ? NULL_SLOT : 11'(i - 1);
        end
        free_top = 11'd0;
        for (int c = 0; c < CLIENTS; c++) begin
            q_first[c] = NULL_SLOT;
            q_last[c]  = NULL_SLOT;
            q_len[c]   = 11'd0;
            q_hnd[c]   = 14'd0;
        end
        client_mask = 64'd0;
    endfunction

    // Apply one item to the mirror and return the reply it must produce.
    function automatic reply_t apply_item(logic [127:0] d);
        lmqp_pkg::cmd_t op;
        logic [6:0]  cs;
        logic [13:0] want;
        logic [10:0] s, nx, pv;
        int          c, steps;
        reply_t      r;
        op   = lmqp_pkg::cmd_t'(d[1:0]);
        cs   = d[8:2];
        want = d[126:113];
        r    = '0;
        r.status = lmqp_pkg::ST_OK;
        if (cs == 7'd0 || cs > CLIENTS || !client_mask[cs - 7'd1]) begin
            r.status = lmqp_pkg::ST_BAD;
            return r;
        end
        c = cs - 1;
        case (op)
            lmqp_pkg::CMD_ENQ: begin
                s = free_top;
                if (!valid_slot(s)) begin
                    r.status = lmqp_pkg::ST_POOL;
                end else begin
                    free_top = link_next[s];
                    if (valid_slot(free_top)) link_prev[free_top] = NULL_SLOT;
                    q_hnd[c] = (q_hnd[c] >= 14'(lmqp_pkg::HANDLE_MAX)) ? 14'd1
                                                                      : q_hnd[c] + 14'd1;
                    r.handle = q_hnd[c];
                    slot_hnd[s] = q_hnd[c];
                    slot_ty[s]  = d[16:9];
                    slot_tm[s]  = d[48:17];
                    slot_pay[s] = d[112:49];
                    link_next[s] = NULL_SLOT;
                    if (valid_slot(q_last[c])) begin
                        link_next[q_last[c]] = s;
                        link_prev[s] = q_last[c];
                    end else begin
                        q_first[c] = s;
                        link_prev[s] = NULL_SLOT;
                    end
                    q_last[c] = s;
                    q_len[c]  = q_len[c] + 11'd1;
                end
            end
            lmqp_pkg::CMD_REMOVE: begin
                r.status = lmqp_pkg::ST_NOTFOUND;
                s = q_first[c];
                steps = 0;
                while (valid_slot(s) && steps < SLOTS) begin
                    nx = link_next[s];
                    pv = link_prev[s];
                    if (slot_hnd[s] == want) begin
                        if (valid_slot(nx)) link_prev[nx] = pv;
                        else q_last[c] = pv;
                        if (valid_slot(pv)) link_next[pv] = nx;
                        else q_first[c] = nx;
                        // Freed slot goes on top of the free list.
                        if (valid_slot(free_top)) link_prev[free_top] = s;
                        link_prev[s] = NULL_SLOT;
                        link_next[s] = free_top;
                        free_top = s;
                        if (q_len[c] != 0) q_len[c] = q_len[c] - 11'd1;
                        r.status = lmqp_pkg::ST_OK;
                        break;
                    end
                    s = nx;
                    steps++;
                end
            end
            lmqp_pkg::CMD_READ: begin
                s = q_first[c];
                if (valid_slot(s)) begin
                    r.handle = slot_hnd[s];
                    r.htime  = slot_tm[s];
                    r.htype  = slot_ty[s];
                    r.hpay   = slot_pay[s];
                end else begin
                    r.status = lmqp_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        r.count = q_len[c];
        return r;
    endfunction

    // Compare outgoing items first, then record the expectation of a new one.
    always @(posedge aclk) begin
        reply_t exp_r;
        int     errs;
        errs = errors;
        if (!aresetn) begin
            clear_pool();
            replies_due.delete();
            errs = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result item with no expectation waiting");
                    errs++;
                end else begin
                    exp_r = replies_due.pop_front();
                    if (m_tdata[1:0] != exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, m_tdata[1:0]);
                        errs++;
                    end
                    if (m_tdata[15:2] != exp_r.handle) begin
                        $error("out_handle exp %0d got %0d", exp_r.handle, m_tdata[15:2]);
                        errs++;
                    end
                    if (m_tdata[47:16] != exp_r.htime) begin
                        $error("head_time exp %0h got %0h", exp_r.htime, m_tdata[47:16]);
                        errs++;
                    end
                    if (m_tdata[55:48] != exp_r.htype) begin
                        $error("head_type exp %0h got %0h", exp_r.htype, m_tdata[55:48]);
                        errs++;
                    end
                    if (m_tdata[119:56] != exp_r.hpay) begin
                        $error("head_payload exp %0h got %0h", exp_r.hpay, m_tdata[119:56]);
                        errs++;
                    end
                    if (m_tdata[130:120] != exp_r.count) begin
                        $error("msg_count exp %0d got %0d", exp_r.count, m_tdata[130:120]);
                        errs++;
                    end
                end
            end
            if (cfg_we) client_mask = cfg_wdata;
            if (s_tvalid && s_tready) replies_due.push_back(apply_item(s_tdata));
        end
        errors  <= errs;
        pending <= replies_due.size();
    end

    initial begin
        errors  = 0;
        pending = 0;
        clear_pool();
    end
endmodule
`default_nettype wire

// ===== test/tb_linked_message_queue_pool.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_linked_message_queue_pool;
    localparam int POOL_SIZE  = 1024;
    localparam int WATCHDOG   = 20000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    int           errors;
    int           pending;

    // Stimulus-side bookkeeping of live handles, used to build valid removes.
    logic [63:0]  mask_now;
    int           live_handles [64][$];
    int           last_hnd [64];
    int           live_total;
    bit           idle_on;
    int           stall_left;
    int           quiet_cycles;

    linked_message_queue_pool dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lmqp_scoreboard u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver stalls in random bursts while idling is enabled.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL linked_message_queue_pool");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit client_ok(int cs);
        return cs >= 1 && cs <= 64 && mask_now[cs - 1];
    endfunction

    // Mostly an active client, sometimes any index at all.
    function automatic int pick_client();
        int cs;
        if (mask_now == 64'd0 || $urandom_range(0, 6) == 0) return $urandom_range(0, 127);
        do cs = $urandom_range(1, 64); while (!mask_now[cs - 1]);
        return cs;
    endfunction

    task automatic send_item(lmqp_pkg::cmd_t op, int cs, logic [7:0] ty, logic [31:0] tm,
                             logic [63:0] pay, logic [13:0] rh);
        int c, idx;
        s_tdata  <= {1'b0, rh, pay, tm, ty, 7'(cs), op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        // Track what the item does to the live handle set.
        if (client_ok(cs)) begin
            c = cs - 1;
            if (op == lmqp_pkg::CMD_ENQ && live_total < POOL_SIZE) begin
                last_hnd[c] = (last_hnd[c] >= lmqp_pkg::HANDLE_MAX) ? 1 : last_hnd[c] + 1;
                live_handles[c].push_back(last_hnd[c]);
                live_total++;
            end else if (op == lmqp_pkg::CMD_REMOVE) begin
                idx = -1;
                foreach (live_handles[c][i]) if (idx < 0 && live_handles[c][i] == rh) idx = i;
                if (idx >= 0) begin
                    live_handles[c].delete(idx);
                    live_total--;
                end
            end
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic enqueue(int cs);
        send_item(lmqp_pkg::CMD_ENQ, cs, 8'($urandom), $urandom, {$urandom, $urandom}, 14'd0);
    endtask

    // Mostly remove a live handle of the client when there is one, else a random handle.
    task automatic remove_some(int cs);
        int n;
        logic [13:0] rh;
        rh = 14'($urandom_range(0, lmqp_pkg::HANDLE_MAX));
        if (client_ok(cs)) begin
            n = live_handles[cs - 1].size();
            if (n != 0 && $urandom_range(0, 5) != 0)
                rh = 14'(live_handles[cs - 1][$urandom_range(0, n - 1)]);
        end
        send_item(lmqp_pkg::CMD_REMOVE, cs, 8'($urandom), $urandom, {$urandom, $urandom}, rh);
    endtask

    task automatic random_item();
        int cs;
        cs = pick_client();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: enqueue(cs);
            4, 5, 6:    remove_some(cs);
            7, 8:       send_item(lmqp_pkg::CMD_READ, cs, 8'($urandom), $urandom,
                                  {$urandom, $urandom}, 14'($urandom));
            default:    send_item(lmqp_pkg::CMD_COUNT, cs, 8'($urandom), $urandom,
                                  {$urandom, $urandom}, 14'($urandom));
        endcase
    endtask

    // Register writes happen only once every result has come back.
    task automatic write_mask(logic [63:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        mask_now  = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= 64'd0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        m_tready   <= 1'b1;
        idle_on    = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        mask_now   = 64'd0;
        live_total = 0;
        foreach (last_hnd[i]) last_hnd[i] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // No client exists after reset: everything is a bad client.
        send_item(lmqp_pkg::CMD_ENQ, 1, 8'hFF, 32'hFFFF_FFFF, '1, 14'd0);
        send_item(lmqp_pkg::CMD_COUNT, 64, 8'd0, 32'd0, 64'd0, 14'd0);

        // All clients active: edge indexes, empty queue cases, extreme fields.
        write_mask('1);
        send_item(lmqp_pkg::CMD_READ, 0, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_READ, 65, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_COUNT, 127, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_READ, 1, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_REMOVE, 1, 8'd0, 32'd0, 64'd0, 14'd1);
        send_item(lmqp_pkg::CMD_ENQ, 1, 8'hFF, 32'hFFFF_FFFF, '1, 14'h3FFF);
        send_item(lmqp_pkg::CMD_ENQ, 1, 8'h00, 32'h0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_ENQ, 64, 8'hA5, 32'h8000_0001, 64'h8000_0000_0000_0001,
                  14'd0);
        send_item(lmqp_pkg::CMD_READ, 1, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_READ, 64, 8'hFF, 32'hFFFF_FFFF, '1, 14'h3FFF);
        send_item(lmqp_pkg::CMD_COUNT, 1, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_REMOVE, 1, 8'd0, 32'd0, 64'd0, 14'(lmqp_pkg::HANDLE_MAX));
        send_item(lmqp_pkg::CMD_REMOVE, 1, 8'd0, 32'd0, 64'd0, 14'd2);
        send_item(lmqp_pkg::CMD_REMOVE, 1, 8'd0, 32'd0, 64'd0, 14'd1);
        send_item(lmqp_pkg::CMD_READ, 1, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_REMOVE, 64, 8'd0, 32'd0, 64'd0, 14'd1);

        // Only the first and last client: neighbors are bad clients.
        write_mask(64'h8000_0000_0000_0001);
        send_item(lmqp_pkg::CMD_ENQ, 2, 8'd1, 32'd1, 64'd1, 14'd0);
        send_item(lmqp_pkg::CMD_COUNT, 63, 8'd0, 32'd0, 64'd0, 14'd0);
        send_item(lmqp_pkg::CMD_COUNT, 64, 8'd0, 32'd0, 64'd0, 14'd0);

        // Random traffic under a random mask, then all clients, last part quiet.
        idle_on = 1'b1;
        write_mask({$urandom, $urandom});
        repeat (250) random_item();
        write_mask('1);
        repeat (150) random_item();
        idle_on = 1'b0;
        repeat (100) random_item();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS linked_message_queue_pool");
        end else begin
            $display("FAIL linked_message_queue_pool");
        end
        $finish;
    end
endmodule
`default_nettype wire
